>>> hdl/vca_pkg.sv
// Shared types and constants for the voice channel allocator.
// Used by vca_cell and voice_channel_allocator_top; depends on nothing else.
`timescale 1ns / 1ps

package vca_pkg;

   // Operation codes carried in the request's tuser.
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic REG_PLAYER_ENTITY = 1'b0;

   // Width of a voice index on the scan path; holds any index up to 255.
   localparam int VOICE_IDX_W = 8;

   // Remaining life must stay strictly below this limit; the bias turns a
   // signed compare into an unsigned one.
   localparam logic [31:0] LIFE_LIMIT = 32'h7fff_ffff;
   localparam logic [31:0] SIGN_BIAS  = 32'h8000_0000;
   localparam logic [31:0] BEST_INIT  = LIFE_LIMIT ^ SIGN_BIAS;

   // Request fields that every cell sees during a scan.
   typedef struct packed {
      logic        op;
      logic [9:0]  entity;
      logic [2:0]  sub_channel;
      logic [30:0] now;
      logic [4:0]  release_index;
      logic [9:0]  player_entity;
   } probe_type;

   // Running result that travels from cell to cell.
   typedef struct packed {
      logic                   valid;
      logic                   stop;
      logic                   found;
      logic                   active;
      logic [VOICE_IDX_W-1:0] pick;
      logic [31:0]            best;
   } scan_type;

   // Write to one voice, broadcast to all cells.
   typedef struct packed {
      logic                   en;
      logic                   clear;
      logic [VOICE_IDX_W-1:0] idx;
      logic [9:0]             owner;
      logic [2:0]             slot;
      logic [31:0]            end_time;
   } update_type;

endpackage

>>> hdl/voice_channel_allocator_top.sv
// Voice channel allocator: after acceptance, the scan token steps through one voice
// cell per cycle, then the finished scan is latched and the result registered.
// One item is in work at a time and the input reopens only in the cycle after the
// result is registered; a stalled result holds it.
// Synchronous active-high reset clears every voice and sets player_entity to 1.
// Uses vca_pkg and vca_cell.
`timescale 1ns / 1ps

module voice_channel_allocator_top #(
   parameter int NUM_VOICES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: entity[9:0], sub_channel[12:10], now[43:13], sound_length[67:44],
   // release_index[72:68], zero fill [79:73]
   input  logic [79:0] req_tdata,
   // tuser: op
   input  logic        req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: granted[0], voice_index[5:1], was_active[6], zero fill [7]
   output logic [7:0]  rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import vca_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type   state_ff;
   logic [9:0]  player_ff;
   logic        op_ff;
   logic [9:0]  entity_ff;
   logic [2:0]  sub_ff;
   logic [30:0] now_ff;
   logic [23:0] len_ff;
   logic [4:0]  rel_ff;
   logic        start_ff;
   scan_type    fin_ff;
   update_type  update_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;

   probe_type   probe;
   scan_type    chain [NUM_VOICES+1];
   update_type  update_in;
   logic [7:0]  rsp_data_in;
   logic        rel_in_range;
   logic [31:0] pick_wide;
   logic        rsp_free;
   logic        cfg_write;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == REG_PLAYER_ENTITY);
   assign csr_prdata = (csr_paddr[2] == REG_PLAYER_ENTITY) ? {22'd0, player_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_ff <= 10'd1;
      end else if (cfg_write) begin
         player_ff <= csr_pwdata[9:0];
      end
   end

   // Chain of voice cells with the scan token entering at cell zero.
   assign probe = '{op: op_ff, entity: entity_ff, sub_channel: sub_ff, now: now_ff,
                    release_index: rel_ff, player_entity: player_ff};

   always_comb begin
      chain[0]        = '0;
      chain[0].valid  = start_ff;
      chain[0].best   = BEST_INIT;
   end

   for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
      vca_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .probe   (probe),
         .scan_in (chain[g]),
         .update  (update_ff),
         .scan_out(chain[g+1])
      );
   end

   // Result and write-back from the finished scan.
   assign rel_in_range = {27'd0, rel_ff} < NUM_VOICES;
   assign pick_wide    = 32'(fin_ff.pick);

   always_comb begin
      update_in   = '0;
      rsp_data_in = '0;
      if (op_ff == OP_RELEASE) begin
         rsp_data_in[0]   = rel_in_range;
         rsp_data_in[5:1] = rel_ff;
         rsp_data_in[6]   = rel_in_range && fin_ff.active;
         update_in.en     = rel_in_range;
         update_in.clear  = 1'b1;
         update_in.idx    = {3'd0, rel_ff};
      end else if (fin_ff.found) begin
         rsp_data_in[0]     = 1'b1;
         rsp_data_in[5:1]   = pick_wide[4:0];
         rsp_data_in[6]     = fin_ff.active;
         update_in.en       = 1'b1;
         update_in.idx      = fin_ff.pick;
         update_in.owner    = entity_ff;
         update_in.slot     = sub_ff;
         update_in.end_time = {1'b0, now_ff} + {8'd0, len_ff};
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: accept, scan, then hand the result to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         update_ff.en <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= 1'b0;
         update_ff.en <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  start_ff <= 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (chain[NUM_VOICES].valid) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  update_ff.en <= update_in.en;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      // Payload registers.
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff     <= req_tuser;
         entity_ff <= req_tdata[9:0];
         sub_ff    <= req_tdata[12:10];
         now_ff    <= req_tdata[43:13];
         len_ff    <= req_tdata[67:44];
         rel_ff    <= req_tdata[72:68];
      end
      if (state_ff == ST_SCAN && chain[NUM_VOICES].valid) begin
         fin_ff <= chain[NUM_VOICES];
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_data_ff        <= rsp_data_in;
         update_ff.clear    <= update_in.clear;
         update_ff.idx      <= update_in.idx;
         update_ff.owner    <= update_in.owner;
         update_ff.slot     <= update_in.slot;
         update_ff.end_time <= update_in.end_time;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/vca_cell.sv
// One voice of the allocator: holds the voice's state and refines the
// running scan result before handing it to the next cell. Uses vca_pkg.
`timescale 1ns / 1ps

module vca_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  vca_pkg::probe_type  probe,
   input  vca_pkg::scan_type   scan_in,
   input  vca_pkg::update_type update,
   output vca_pkg::scan_type   scan_out
);
   import vca_pkg::*;

   localparam logic [VOICE_IDX_W-1:0] MY_IDX = VOICE_IDX_W'(CELL_INDEX);

   logic        active_ff, active_in;
   logic [9:0]  owner_ff, owner_in;
   logic [2:0]  slot_ff, slot_in;
   logic [31:0] end_ff, end_in;
   scan_type    scan_ff, scan_in_next;

   logic        same_owner;
   logic        protected_voice;
   logic [31:0] life;

   // Voice state update from the write-back broadcast.
   always_comb begin
      active_in = active_ff;
      owner_in  = owner_ff;
      slot_in   = slot_ff;
      end_in    = end_ff;
      if (update.en && update.idx == MY_IDX) begin
         if (update.clear) begin
            active_in = 1'b0;
            owner_in  = '0;
            slot_in   = '0;
            end_in    = '0;
         end else begin
            active_in = 1'b1;
            owner_in  = update.owner;
            slot_in   = update.slot;
            end_in    = update.end_time;
         end
      end
   end

   // Comparison of this voice against the running result.
   assign same_owner = (probe.sub_channel != 3'd0) && (owner_ff == probe.entity) &&
                       (slot_ff == probe.sub_channel);
   assign protected_voice = (owner_ff == probe.player_entity) &&
                            (probe.entity != probe.player_entity) && active_ff;
   assign life = (end_ff - {1'b0, probe.now}) ^ SIGN_BIAS;

   always_comb begin
      scan_in_next = scan_in;
      if (scan_in.valid) begin
         if (probe.op == OP_RELEASE) begin
            if ({3'd0, probe.release_index} == MY_IDX) begin
               scan_in_next.active = active_ff;
               scan_in_next.pick   = MY_IDX;
            end
         end else if (!scan_in.stop) begin
            if (same_owner) begin
               scan_in_next.stop   = 1'b1;
               scan_in_next.found  = 1'b1;
               scan_in_next.pick   = MY_IDX;
               scan_in_next.active = active_ff;
            end else if (!protected_voice && life < scan_in.best) begin
               scan_in_next.best   = life;
               scan_in_next.found  = 1'b1;
               scan_in_next.pick   = MY_IDX;
               scan_in_next.active = active_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         owner_ff      <= '0;
         slot_ff       <= '0;
         end_ff        <= '0;
         scan_ff.valid <= 1'b0;
      end else begin
         active_ff     <= active_in;
         owner_ff      <= owner_in;
         slot_ff       <= slot_in;
         end_ff        <= end_in;
         scan_ff.valid <= scan_in_next.valid;
      end
      scan_ff.stop   <= scan_in_next.stop;
      scan_ff.found  <= scan_in_next.found;
      scan_ff.active <= scan_in_next.active;
      scan_ff.pick   <= scan_in_next.pick;
      scan_ff.best   <= scan_in_next.best;
   end

   assign scan_out = scan_ff;

endmodule
